@@ src/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, s-box table and round functions for the aes block encryptor
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned STORE_DEPTH = 30;
    localparam int unsigned NUM_STAGES  = 15;
    localparam int unsigned MID_128     = 10 - 1;
    localparam int unsigned MID_256     = 14 - 1;
    localparam int unsigned WORDS_128   = 44;
    localparam int unsigned WORDS_256   = 60;

    localparam logic [2:0] REG_KEY_SIZE  = 3'd0;
    localparam logic [2:0] REG_KEY_WORD0 = 3'd1;
    localparam logic [2:0] REG_KEY_WORD1 = 3'd2;
    localparam logic [2:0] REG_KEY_WORD2 = 3'd3;
    localparam logic [2:0] REG_KEY_WORD3 = 3'd4;

    typedef struct packed {
        logic busy;
        logic key_size;
    } key_stat_t;

    typedef struct packed {
        logic do_sub;
        logic do_mix;
        logic do_key;
    } stage_ctl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte j of the state sits at bits [127-8j -: 8]
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = s[127 - 32 * c -: 8];
            a1  = s[119 - 32 * c -: 8];
            a2  = s[111 - 32 * c -: 8];
            a3  = s[103 - 32 * c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

endpackage

@@ src/aes_key_expand.sv @@
// ----------------------------------------------------------------------------
// aes_key_expand
// key registers and sequential key schedule, one word per cycle into the store
// ----------------------------------------------------------------------------
module aes_key_expand (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    output aes_pkg::key_stat_t     stat,
    output logic [29:0][63:0]      round_keys
);

    logic              key_size_reg;
    logic [63:0]       kw0_reg, kw1_reg, kw2_reg, kw3_reg;
    logic              start_reg;
    logic              run_reg;
    logic [5:0]        cnt_reg;
    logic [7:0]        rcon_reg;
    logic [31:0]       win_reg [8];
    logic [29:0][63:0] store_reg;

    logic [5:0]  total;
    logic [31:0] t_word;
    logic [31:0] far_word;
    logic [31:0] new_word;
    logic        rot_step;
    logic        cfg_hit;

    assign total    = key_size_reg ? 6'(aes_pkg::WORDS_256) : 6'(aes_pkg::WORDS_128);
    assign rot_step = key_size_reg ? (cnt_reg[2:0] == 3'd0) : (cnt_reg[1:0] == 2'd0);
    assign far_word = key_size_reg ? win_reg[0] : win_reg[4];
    assign cfg_hit  = cfg_wr_en && (cfg_index <= aes_pkg::REG_KEY_WORD3);

    always_comb begin
        t_word = win_reg[7];
        if (rot_step) begin
            t_word = aes_pkg::sub_word({win_reg[7][23:0], win_reg[7][31:24]})
                   ^ {rcon_reg, 24'h0};
        end else if (key_size_reg && cnt_reg[2:0] == 3'd4) begin
            t_word = aes_pkg::sub_word(win_reg[7]);
        end
        new_word = far_word ^ t_word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_size_reg <= 1'b0;
            kw0_reg      <= '0;
            kw1_reg      <= '0;
            kw2_reg      <= '0;
            kw3_reg      <= '0;
            start_reg    <= 1'b1;
            run_reg      <= 1'b0;
        end else if (cfg_hit) begin
            case (cfg_index)
                aes_pkg::REG_KEY_SIZE:  key_size_reg <= cfg_data[0];
                aes_pkg::REG_KEY_WORD0: kw0_reg      <= cfg_data;
                aes_pkg::REG_KEY_WORD1: kw1_reg      <= cfg_data;
                aes_pkg::REG_KEY_WORD2: kw2_reg      <= cfg_data;
                aes_pkg::REG_KEY_WORD3: kw3_reg      <= cfg_data;
                default: ;
            endcase
            start_reg <= 1'b1;
            run_reg   <= 1'b0;
        end else if (start_reg) begin
            start_reg <= 1'b0;
            run_reg   <= 1'b1;
        end else if (run_reg && cnt_reg + 6'd1 == total) begin
            run_reg <= 1'b0;
        end
    end

    // datapath of the schedule, no reset
    always_ff @(posedge aclk) begin
        if (start_reg) begin
            rcon_reg     <= 8'h01;
            store_reg[0] <= kw0_reg;
            store_reg[1] <= kw1_reg;
            win_reg[4]   <= kw0_reg[63:32];
            win_reg[5]   <= kw0_reg[31:0];
            win_reg[6]   <= kw1_reg[63:32];
            win_reg[7]   <= kw1_reg[31:0];
            if (key_size_reg) begin
                store_reg[2] <= kw2_reg;
                store_reg[3] <= kw3_reg;
                win_reg[0]   <= kw0_reg[63:32];
                win_reg[1]   <= kw0_reg[31:0];
                win_reg[2]   <= kw1_reg[63:32];
                win_reg[3]   <= kw1_reg[31:0];
                win_reg[4]   <= kw2_reg[63:32];
                win_reg[5]   <= kw2_reg[31:0];
                win_reg[6]   <= kw3_reg[63:32];
                win_reg[7]   <= kw3_reg[31:0];
                cnt_reg      <= 6'd8;
            end else begin
                cnt_reg <= 6'd4;
            end
        end else if (run_reg) begin
            for (int k = 0; k < 7; k++) begin
                win_reg[k] <= win_reg[k + 1];
            end
            win_reg[7] <= new_word;
            if (cnt_reg[0]) begin
                store_reg[cnt_reg[5:1]][31:0] <= new_word;
            end else begin
                store_reg[cnt_reg[5:1]][63:32] <= new_word;
            end
            if (rot_step) begin
                rcon_reg <= aes_pkg::xtime(rcon_reg);
            end
            cnt_reg <= cnt_reg + 6'd1;
        end
    end

    assign stat.busy     = start_reg || run_reg;
    assign stat.key_size = key_size_reg;
    assign round_keys    = store_reg;

endmodule

@@ src/aes_round_stage.sv @@
// ----------------------------------------------------------------------------
// aes_round_stage
// one registered round of the cipher pipeline
// ----------------------------------------------------------------------------
module aes_round_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  aes_pkg::stage_ctl_t  ctl,
    input  logic                 in_valid,
    input  logic [127:0]         in_state,
    input  logic [127:0]         round_key,
    output logic                 out_valid,
    output logic [127:0]         out_state
);

    logic         valid_reg;
    logic [127:0] state_reg;
    logic [127:0] state_next;
    logic [127:0] sub_val;
    logic [127:0] mix_val;

    always_comb begin
        sub_val    = ctl.do_sub ? aes_pkg::sub_shift(in_state) : in_state;
        mix_val    = ctl.do_mix ? aes_pkg::mix_columns(sub_val) : sub_val;
        state_next = ctl.do_key ? (mix_val ^ round_key) : mix_val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            state_reg <= state_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

@@ src/aes_block_encrypt.sv @@
// ----------------------------------------------------------------------------
// aes_block_encrypt
// fips-197 aes-128 / aes-256 ecb encryption, fully unrolled round pipeline
// ----------------------------------------------------------------------------
// key add plus 14 round stages; aes-128 passes the last four stages unchanged
// throughput: one block per cycle while the result is not stalled and the
// key schedule is idle, set by one round per pipeline stage
// reset: synchronous active-low aresetn clears the key registers and then
// expands the all-zero aes-128 key; after reset or any key register write the
// schedule runs with s_ready low
module aes_block_encrypt (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // plaintext channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_plain_hi,
    input  logic [63:0] s_plain_lo,
    // ciphertext channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_cipher_hi,
    output logic [63:0] m_cipher_lo
);

    localparam int unsigned NS = aes_pkg::NUM_STAGES;

    aes_pkg::key_stat_t  kstat;
    logic [29:0][63:0]   round_keys;
    logic                advance;
    logic                s_accept;
    logic [3:0]          mid;
    logic                stage_valid [NS];
    logic [127:0]        stage_state [NS];

    // key registers and round key schedule
    aes_key_expand u_key (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .stat       (kstat),
        .round_keys (round_keys)
    );

    // whole pipeline moves together; it holds only when the result is stalled
    assign advance  = !stage_valid[NS-1] || m_ready;
    assign s_ready  = advance && !kstat.busy;
    assign s_accept = s_valid && s_ready;
    assign mid      = kstat.key_size ? 4'(aes_pkg::MID_256) : 4'(aes_pkg::MID_128);

    // stage 0: initial round key add
    aes_round_stage u_stage0 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .ctl       ('{do_sub: 1'b0, do_mix: 1'b0, do_key: 1'b1}),
        .in_valid  (s_accept),
        .in_state  ({s_plain_hi, s_plain_lo}),
        .round_key ({round_keys[0], round_keys[1]}),
        .out_valid (stage_valid[0]),
        .out_state (stage_state[0])
    );

    // stages 1..14: middle rounds, the final round, then pass-through (aes-128 only)
    for (genvar r = 1; r < NS; r++) begin : g_round
        aes_pkg::stage_ctl_t ctl;
        always_comb begin
            ctl.do_sub = (4'(r) <= mid + 4'd1);
            ctl.do_mix = (4'(r) <= mid);
            ctl.do_key = (4'(r) <= mid + 4'd1);
        end
        aes_round_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (advance),
            .ctl       (ctl),
            .in_valid  (stage_valid[r-1]),
            .in_state  (stage_state[r-1]),
            .round_key ({round_keys[2*r], round_keys[2*r+1]}),
            .out_valid (stage_valid[r]),
            .out_state (stage_state[r])
        );
    end

    assign m_valid     = stage_valid[NS-1];
    assign m_cipher_hi = stage_state[NS-1][127:64];
    assign m_cipher_lo = stage_state[NS-1][63:0];

`ifndef SYNTHESIS
    // no transaction while the schedule rewrites the store
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        kstat.busy |-> !s_accept)
        else $error("input accepted during key expansion");

    // a key register write starts the schedule
    a_cfg_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr_en && cfg_index <= aes_pkg::REG_KEY_WORD3) |=> kstat.busy)
        else $error("key write did not start expansion");

    // an accepted block reaches the first stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> stage_valid[0])
        else $error("accepted block lost at pipeline entry");

    // a stalled result is held in place
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> stage_valid[NS-1] && $stable(stage_state[NS-1]))
        else $error("stalled result changed");
`endif

endmodule
